// File: sv/lru_page_replacement_top_assert.svh
// Assertion macros used by the page replacement top level.
`ifndef LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LRUPR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define LRUPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/lrupr_pkg.sv
// Shared types for the page replacement block: sequencer states, scan flags and cell control.
package lrupr_pkg;

   // Sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOK   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   // Prefix flags that ripple from frame 0 upward
   typedef struct packed {
      logic hit_seen;
      logic empty_seen;
   } scan_type;

   // Control broadcast from the sequencer to every cell
   typedef struct packed {
      logic look;
      logic update;
      logic hit_any;
      logic empty_any;
      logic write_page;
   } ctrl_type;

endpackage

// File: sv/lrupr_cell.sv
// One frame cell: holds page, valid and recency rank, and joins the scan and collect chains.
module lrupr_cell #(
   parameter int FRAMES    = 4,
   parameter int PAGE_BITS = 8,
   parameter int INDEX     = 0,
   localparam int IDX_W    = $clog2(FRAMES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lrupr_pkg::ctrl_type   ctrl,
   input  logic [PAGE_BITS-1:0]  page,
   input  logic [IDX_W-1:0]      sel_rank,
   input  lrupr_pkg::scan_type   scan_prev,
   output lrupr_pkg::scan_type   scan_next,
   input  logic [IDX_W-1:0]      idx_prev,
   output logic [IDX_W-1:0]      idx_next,
   input  logic [IDX_W-1:0]      rank_prev,
   output logic [IDX_W-1:0]      rank_next,
   input  logic [PAGE_BITS-1:0]  evict_prev,
   output logic [PAGE_BITS-1:0]  evict_next,
   output logic [IDX_W-1:0]      cell_rank
);

   logic [PAGE_BITS-1:0] page_ff;
   logic                 valid_ff;
   logic [IDX_W-1:0]     rank_ff;
   logic                 sel_ff;
   logic                 match;
   logic                 sel_now;

   // Compare against the request; an empty frame never matches
   assign match = valid_ff && (page_ff == page);

   // Extend the prefix flags to the next cell
   assign scan_next.hit_seen   = scan_prev.hit_seen | match;
   assign scan_next.empty_seen = scan_prev.empty_seen | ~valid_ff;

   // Claim the frame: first hit, else first empty, else least recent
   always_comb begin
      if (ctrl.hit_any) begin
         sel_now = match && !scan_prev.hit_seen;
      end else if (ctrl.empty_any) begin
         sel_now = !valid_ff && !scan_prev.empty_seen;
      end else begin
         sel_now = (rank_ff == '0);
      end
   end

   // Merge this cell's index, rank and victim page into the collect chain
   assign idx_next   = idx_prev | (sel_now ? IDX_W'(INDEX) : '0);
   assign rank_next  = rank_prev | (sel_now ? rank_ff : '0);
   assign evict_next = evict_prev |
                       ((sel_now && !ctrl.hit_any && !ctrl.empty_any) ? page_ff : '0);
   assign cell_rank  = rank_ff;

   // Hold frame state; latch the claim in lookup, apply it in update
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= IDX_W'(INDEX);
         sel_ff   <= 1'b0;
      end else begin
         if (ctrl.look) begin
            sel_ff <= sel_now;
         end
         if (ctrl.update) begin
            if (sel_ff) begin
               rank_ff <= IDX_W'(FRAMES - 1);
               if (ctrl.write_page) begin
                  valid_ff <= 1'b1;
               end
            end else if (rank_ff > sel_rank) begin
               rank_ff <= rank_ff - 1'b1;
            end
         end
      end
   end

   // Store the page on a miss
   always_ff @(posedge clock) begin
      if (ctrl.update && ctrl.write_page && sel_ff) begin
         page_ff <= page;
      end
   end

endmodule

// File: sv/lru_page_replacement_top.sv
// Top level: fully associative LRU page replacement built as a row of frame cells.
//
//  channel   ports                                   beat marked by
//  request   req_page_number                         start && !busy
//  response  rsp_hit, rsp_frame_index,               rsp_valid (one cycle)
//            rsp_evicted_valid, rsp_evicted_page
//
// An access runs from start through lookup and update, and its response beat comes
// while the block is idle again, when the next start can already be accepted.
// Lookup ripples the hit and empty scans and the collect chain across all FRAMES cells.
// Reset is synchronous; after it every frame is empty and frame 0 is least recent.
// The response cannot be stalled: rsp_valid is high for exactly one cycle per access.
`include "lru_page_replacement_top_assert.svh"

module lru_page_replacement_top #(
   parameter int FRAMES    = 4,
   parameter int PAGE_BITS = 8,
   localparam int IDX_W    = $clog2(FRAMES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [PAGE_BITS-1:0] req_page_number,
   output logic                 rsp_valid,
   output logic                 rsp_hit,
   output logic [IDX_W-1:0]     rsp_frame_index,
   output logic                 rsp_evicted_valid,
   output logic [PAGE_BITS-1:0] rsp_evicted_page
);

   lrupr_pkg::state_type state_ff, state_in;
   lrupr_pkg::ctrl_type  ctrl;

   logic [PAGE_BITS-1:0] page_ff;
   logic                 hit_ff;
   logic                 empty_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     sel_rank_ff;
   logic [PAGE_BITS-1:0] evict_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [IDX_W-1:0]     rsp_idx_ff;
   logic                 rsp_ev_valid_ff;
   logic [PAGE_BITS-1:0] rsp_ev_page_ff;

   lrupr_pkg::scan_type  scan [FRAMES+1];
   logic [IDX_W-1:0]     idx_chain [FRAMES+1];
   logic [IDX_W-1:0]     rank_chain [FRAMES+1];
   logic [PAGE_BITS-1:0] evict_chain [FRAMES+1];
   logic [IDX_W-1:0]     cell_rank [FRAMES];
   logic [FRAMES-1:0]    rank_seen;
   logic                 accept;

   assign busy   = (state_ff != lrupr_pkg::ST_IDLE);
   assign accept = start && !busy;

   // Advance lookup -> update -> idle
   always_comb begin
      unique case (state_ff)
         lrupr_pkg::ST_IDLE:   state_in = accept ? lrupr_pkg::ST_LOOK : lrupr_pkg::ST_IDLE;
         lrupr_pkg::ST_LOOK:   state_in = lrupr_pkg::ST_UPDATE;
         lrupr_pkg::ST_UPDATE: state_in = lrupr_pkg::ST_IDLE;
         default:              state_in = lrupr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrupr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Drive cell control: live hit and empty scan results, and the latched hit for the page write
   assign ctrl.look       = (state_ff == lrupr_pkg::ST_LOOK);
   assign ctrl.update     = (state_ff == lrupr_pkg::ST_UPDATE);
   assign ctrl.hit_any    = scan[FRAMES].hit_seen;
   assign ctrl.empty_any  = scan[FRAMES].empty_seen;
   assign ctrl.write_page = !hit_ff;

   // Seed the chains at frame 0
   assign scan[0].hit_seen   = 1'b0;
   assign scan[0].empty_seen = 1'b0;
   assign idx_chain[0]       = '0;
   assign rank_chain[0]      = '0;
   assign evict_chain[0]     = '0;

   // Build the row of frame cells
   for (genvar g = 0; g < FRAMES; g++) begin : g_cell
      lrupr_cell #(
         .FRAMES    (FRAMES),
         .PAGE_BITS (PAGE_BITS),
         .INDEX     (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .page       (page_ff),
         .sel_rank   (sel_rank_ff),
         .scan_prev  (scan[g]),
         .scan_next  (scan[g+1]),
         .idx_prev   (idx_chain[g]),
         .idx_next   (idx_chain[g+1]),
         .rank_prev  (rank_chain[g]),
         .rank_next  (rank_chain[g+1]),
         .evict_prev (evict_chain[g]),
         .evict_next (evict_chain[g+1]),
         .cell_rank  (cell_rank[g])
      );
   end

   // Capture the request page on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff <= req_page_number;
      end
   end

   // Hold lookup results for the update cycle
   always_ff @(posedge clock) begin
      if (ctrl.look) begin
         hit_ff      <= scan[FRAMES].hit_seen;
         empty_ff    <= scan[FRAMES].empty_seen;
         idx_ff      <= idx_chain[FRAMES];
         sel_rank_ff <= rank_chain[FRAMES];
         evict_ff    <= evict_chain[FRAMES];
      end
   end

   // Register the response beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.update;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.update) begin
         rsp_hit_ff      <= hit_ff;
         rsp_idx_ff      <= idx_ff;
         rsp_ev_valid_ff <= !hit_ff && !empty_ff;
         rsp_ev_page_ff  <= evict_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_idx_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;

   // Mark which ranks are held, for the permutation check
   always_comb begin
      rank_seen = '0;
      for (int i = 0; i < FRAMES; i++) begin
         rank_seen[cell_rank[i]] = 1'b1;
      end
   end

   `LRUPR_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_ff), "state not one-hot")
   `LRUPR_ASSERT_NOW(a_rank_perm, 1'b1, &rank_seen, "recency ranks not a permutation")
   `LRUPR_ASSERT_NOW(a_hit_no_evict, rsp_valid, !(rsp_hit && rsp_evicted_valid), "hit with eviction")
   `LRUPR_ASSERT_NOW(a_evict_zero, rsp_valid && !rsp_evicted_valid, rsp_evicted_page == '0, "stray evicted page")
   `LRUPR_ASSERT_NEXT(a_accept_busy, accept, busy && !rsp_valid, "accept did not start lookup")

endmodule
